// ===== rtl/core/pss_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pss_pkg
// Shared types and constants for the pattern step sequencer.
// ----------------------------------------------------------------------------
package pss_pkg;

  localparam int TRACK_COUNT_DEF = 8;
  localparam int STEP_COUNT_DEF  = 16;

  localparam int        TPS_W     = 20;
  localparam logic [19:0] TPS_RESET = 20'd5512;

  typedef enum logic [2:0] {
    CMD_TICK   = 3'd0,
    CMD_TOGGLE = 3'd1,
    CMD_SET    = 3'd2,
    CMD_READ   = 3'd3,
    CMD_PLAY   = 3'd4
  } cmd_t;

  typedef struct packed {
    logic [2:0] command;
    logic [2:0] track;
    logic [3:0] step_index;
    logic       value;
  } in_item_t;

  typedef struct packed {
    logic [7:0] trigger_mask;
    logic [3:0] fired_step;
    logic       read_value;
    logic       playing;
  } out_item_t;

endpackage
`default_nettype wire

// ===== rtl/core/pattern_step_sequencer.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pattern_step_sequencer
// Track by step grid of trigger bits, sample tick counter and step pointer;
// each item is a tick or a grid/playback command and yields one result item.
// ----------------------------------------------------------------------------
//  channel  | ports                           | direction
//  ---------+---------------------------------+----------
//  input    | in_valid, in_ready, in_item     | in
//  result   | out_valid, out_ready, out_item  | out
//  config   | cfg_we, cfg_wdata               | in
//
// one item per cycle while results are taken; a result is offered once its item has
// passed the input register and then the result register (state updated as it loads)
// the grid, counter and step pointer are flip-flops, so the next item sees the
// previous item's updates with no extra wait
// rst_n is synchronous: clears the grid, active flags, step, counter and
// playback, and loads the default ticks per step
// a stalled result holds the result register; the input register still takes
// an item while it is empty or the result register is free or being emptied
// ----------------------------------------------------------------------------
module pattern_step_sequencer
  import pss_pkg::*;
#(
  parameter int TRACK_COUNT = TRACK_COUNT_DEF,
  parameter int STEP_COUNT  = STEP_COUNT_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire in_item_t         in_item,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output out_item_t             out_item,
  input  wire logic             cfg_we,
  input  wire logic [TPS_W-1:0] cfg_wdata
);

  localparam int STEP_W = $clog2(STEP_COUNT);

  logic                  s1_valid_r, s1_valid_nxt;
  in_item_t              s1_item_r;
  logic                  out_valid_r, out_valid_nxt;
  out_item_t             out_item_r, out_item_nxt;

  logic [STEP_COUNT-1:0] pattern_r [TRACK_COUNT];
  logic [STEP_COUNT-1:0] pattern_nxt [TRACK_COUNT];
  logic [TRACK_COUNT-1:0] active_r, active_nxt;
  logic [STEP_W-1:0]     step_r, step_nxt;
  logic [TPS_W-1:0]      tick_r, tick_nxt;
  logic                  playing_r, playing_nxt;
  logic [TPS_W-1:0]      tps_r;

  logic                  out_load;
  logic                  in_accept;
  logic                  proc;
  logic                  cell_hit [TRACK_COUNT][STEP_COUNT];
  logic [TRACK_COUNT-1:0] col_mask;
  logic [TRACK_COUNT+7:0] mask_ext;
  logic [STEP_W+3:0]     step_ext;
  logic [TPS_W-1:0]      tick_inc;
  logic                  rd_bit;

  assign out_load  = !out_valid_r || out_ready;
  assign in_ready  = !s1_valid_r || out_load;
  assign in_accept = in_valid && in_ready;
  assign proc      = s1_valid_r && out_load;

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // one-hot decode of the addressed grid cell, empty when out of range
  always_comb begin
    for (int t = 0; t < TRACK_COUNT; t++) begin
      for (int s = 0; s < STEP_COUNT; s++) begin
        cell_hit[t][s] = (32'(s1_item_r.track) == t) && (32'(s1_item_r.step_index) == s);
      end
    end
  end

  // column read at the current step, gated by the active flags
  always_comb begin
    for (int t = 0; t < TRACK_COUNT; t++) begin
      col_mask[t] = active_r[t] & pattern_r[t][step_r];
    end
  end

  assign mask_ext = {8'b0, col_mask};
  assign step_ext = {4'b0, step_r};
  assign tick_inc = tick_r + 1'b1;

  always_comb begin
    rd_bit = 1'b0;
    for (int t = 0; t < TRACK_COUNT; t++) begin
      for (int s = 0; s < STEP_COUNT; s++) begin
        rd_bit = rd_bit | (cell_hit[t][s] & pattern_r[t][s]);
      end
    end
  end

  always_comb begin
    for (int t = 0; t < TRACK_COUNT; t++) begin
      pattern_nxt[t] = pattern_r[t];
    end
    active_nxt   = active_r;
    step_nxt     = step_r;
    tick_nxt     = tick_r;
    playing_nxt  = playing_r;
    out_item_nxt = '0;

    if (proc) begin
      case (cmd_t'(s1_item_r.command))
        CMD_TICK: begin
          if (playing_r) begin
            if (tick_inc >= tps_r) begin
              tick_nxt                  = '0;
              out_item_nxt.trigger_mask = mask_ext[7:0];
              out_item_nxt.fired_step   = step_ext[3:0];
              step_nxt = (step_r == STEP_W'(STEP_COUNT - 1)) ? '0 : step_r + 1'b1;
            end else begin
              tick_nxt = tick_inc;
            end
          end
        end
        CMD_TOGGLE: begin
          for (int t = 0; t < TRACK_COUNT; t++) begin
            for (int s = 0; s < STEP_COUNT; s++) begin
              if (cell_hit[t][s]) begin
                pattern_nxt[t][s] = !pattern_r[t][s];
                active_nxt[t]     = 1'b1;
              end
            end
          end
        end
        CMD_SET: begin
          for (int t = 0; t < TRACK_COUNT; t++) begin
            for (int s = 0; s < STEP_COUNT; s++) begin
              if (cell_hit[t][s]) begin
                pattern_nxt[t][s] = s1_item_r.value;
                if (s1_item_r.value) begin
                  active_nxt[t] = 1'b1;
                end
              end
            end
          end
        end
        CMD_READ: begin
          out_item_nxt.read_value = rd_bit;
        end
        CMD_PLAY: begin
          playing_nxt = !playing_r;
          if (playing_r) begin
            step_nxt = '0;
            tick_nxt = '0;
          end
        end
        default: begin
        end
      endcase
      out_item_nxt.playing = playing_nxt;
    end
  end

  always_comb begin
    s1_valid_nxt  = in_accept ? 1'b1 : (out_load ? 1'b0 : s1_valid_r);
    out_valid_nxt = out_load ? s1_valid_r : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      for (int t = 0; t < TRACK_COUNT; t++) begin
        pattern_r[t] <= '0;
      end
      active_r    <= '0;
      step_r      <= '0;
      tick_r      <= '0;
      playing_r   <= 1'b0;
      tps_r       <= TPS_RESET;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      for (int t = 0; t < TRACK_COUNT; t++) begin
        pattern_r[t] <= pattern_nxt[t];
      end
      active_r    <= active_nxt;
      step_r      <= step_nxt;
      tick_r      <= tick_nxt;
      playing_r   <= playing_nxt;
      if (cfg_we) begin
        tps_r <= cfg_wdata;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_item_r <= in_item;
    end
    if (proc) begin
      out_item_r <= out_item_nxt;
    end
  end

endmodule
`default_nettype wire
